// ===== src/i2cms_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cms_pkg
// Shared widths, command codes and phase codes for the I2C master bit engine.
// ----------------------------------------------------------------------------
package i2cms_pkg;

    localparam int unsigned HALF_W  = 16;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned OP_W    = 3;
    localparam int unsigned PHASE_W = 4;
    localparam int unsigned BIT_W   = 3;

    localparam logic [HALF_W-1:0] HALF_RESET = 16'd100;
    localparam logic [BIT_W-1:0]  LAST_BIT   = 3'd7;

    typedef logic [OP_W-1:0]    t_op;
    typedef logic [PHASE_W-1:0] t_phase;
    typedef logic [BYTE_W-1:0]  t_byte;
    typedef logic [HALF_W-1:0]  t_half;

    // command codes
    localparam t_op OP_START = 3'd0;
    localparam t_op OP_STOP  = 3'd1;
    localparam t_op OP_SEND  = 3'd2;
    localparam t_op OP_READ  = 3'd3;
    localparam t_op OP_WACK  = 3'd4;
    localparam t_op OP_ACK   = 3'd5;
    localparam t_op OP_NACK  = 3'd6;
    localparam t_op OP_CHECK = 3'd7;

    // sequence phases
    localparam t_phase PH_ST_REL   = 4'd0;
    localparam t_phase PH_ST_SDA   = 4'd1;
    localparam t_phase PH_ST_SCL   = 4'd2;
    localparam t_phase PH_TX_DATA  = 4'd3;
    localparam t_phase PH_TX_HIGH  = 4'd4;
    localparam t_phase PH_TX_LOW   = 4'd5;
    localparam t_phase PH_RX_HIGH  = 4'd6;
    localparam t_phase PH_RX_LOW   = 4'd7;
    localparam t_phase PH_AK_DATA  = 4'd8;
    localparam t_phase PH_AK_HIGH  = 4'd9;
    localparam t_phase PH_AK_LOW   = 4'd10;
    localparam t_phase PH_SP_LOW   = 4'd11;
    localparam t_phase PH_SP_SCL   = 4'd12;
    localparam t_phase PH_SP_SDA   = 4'd13;

endpackage

// ===== src/i2c_master_bit_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer_top
// I2C master bit engine: one input item per clock tick while the output is not stalled, one result per item.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------
//  in      | in        | i_in_valid/o_in_ready  | cmd_valid, op, tx_byte,
//          |           |                        | sda_in, scl_in
//  out     | out       | o_out_valid/i_out_ready| scl/sda drive, busy, done,
//          |           |                        | rx_byte, ack_bit, bus_owned
//  cfg     | in        | i_cfg_valid/o_cfg_ready| half_period_ticks
//
// One item per cycle sustained while the output is not stalled; an accepted item
// goes from the input register through the sequencer step into the result register.
// The sequencer state advances only when an item moves into the result
// register, so stalls on either side freeze bus time.
// Synchronous active-low reset: sequencer lines released, idle, half period 100.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer_top (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic                    i_cmd_valid,
    input  i2cms_pkg::t_op          i_op,
    input  i2cms_pkg::t_byte        i_tx_byte,
    input  logic                    i_sda_in,
    input  logic                    i_scl_in,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic                    o_scl_drive,
    output logic                    o_sda_drive,
    output logic                    o_busy_res,
    output logic                    o_done_res,
    output i2cms_pkg::t_byte        o_rx_byte,
    output logic                    o_ack_bit,
    output logic                    o_bus_owned,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  i2cms_pkg::t_half        i_cfg_half_period_ticks
);
    import i2cms_pkg::*;

    // input register
    logic   r_iv;
    logic   r_cmd_valid;
    t_op    r_op;
    t_byte  r_tx;
    logic   r_sda_in;
    logic   r_scl_in;

    // sequencer state
    t_half              r_half;
    t_op                r_cmd,    n_cmd;
    t_phase             r_phase,  n_phase;
    t_half              r_dly,    n_dly;
    logic [BIT_W-1:0]   r_bit,    n_bit;
    t_byte              r_shift,  n_shift;
    t_byte              r_rd,     n_rd;
    logic               r_ack,    n_ack;
    logic               r_own,    n_own;
    logic               r_scl,    n_scl;
    logic               r_sda,    n_sda;
    logic               r_active, n_active;
    logic               n_done;

    // result register
    logic   r_ov;
    logic   r_o_scl, r_o_sda, r_o_busy, r_o_done, r_o_ack, r_o_own;
    t_byte  r_o_rx;

    logic   adv;
    logic   begin_en;
    logic   finish;
    t_phase nxt_ph;
    t_half  hold;

    assign adv         = r_iv && (!r_ov || i_out_ready);
    assign o_in_ready  = !r_iv || adv;
    assign o_cfg_ready = 1'b1;
    assign hold        = (r_half == '0) ? t_half'(1) : r_half;

    always_comb begin
        n_cmd    = r_cmd;
        n_phase  = r_phase;
        n_dly    = r_dly;
        n_bit    = r_bit;
        n_shift  = r_shift;
        n_rd     = r_rd;
        n_ack    = r_ack;
        n_own    = r_own;
        n_scl    = r_scl;
        n_sda    = r_sda;
        n_active = r_active;
        n_done   = 1'b0;
        begin_en = 1'b0;
        finish   = 1'b0;
        nxt_ph   = PH_ST_REL;

        if (r_active) begin
            if (r_dly > t_half'(1)) begin
                n_dly = r_dly - t_half'(1);
            end else begin
                begin_en = 1'b1;
                case (r_phase)
                    PH_ST_REL: nxt_ph = PH_ST_SDA;
                    PH_ST_SDA: nxt_ph = PH_ST_SCL;
                    PH_ST_SCL: begin
                        if (r_cmd == OP_CHECK) begin
                            n_bit  = '0;
                            nxt_ph = PH_TX_DATA;
                        end else begin
                            finish = 1'b1;
                        end
                    end
                    PH_TX_DATA: nxt_ph = PH_TX_HIGH;
                    PH_TX_HIGH: nxt_ph = PH_TX_LOW;
                    PH_TX_LOW: begin
                        if (r_bit == LAST_BIT) begin
                            if (r_cmd == OP_CHECK) nxt_ph = PH_AK_DATA;
                            else                   finish = 1'b1;
                        end else begin
                            n_bit  = r_bit + BIT_W'(1);
                            nxt_ph = PH_TX_DATA;
                        end
                    end
                    PH_RX_HIGH: begin
                        n_shift = {r_shift[BYTE_W-2:0], r_sda_in};
                        nxt_ph  = PH_RX_LOW;
                    end
                    PH_RX_LOW: begin
                        if (r_bit == LAST_BIT) begin
                            n_rd   = r_shift;
                            finish = 1'b1;
                        end else begin
                            n_bit  = r_bit + BIT_W'(1);
                            nxt_ph = PH_RX_HIGH;
                        end
                    end
                    PH_AK_DATA: nxt_ph = PH_AK_HIGH;
                    PH_AK_HIGH: begin
                        if (r_cmd == OP_WACK || r_cmd == OP_CHECK) n_ack = r_sda_in;
                        nxt_ph = PH_AK_LOW;
                    end
                    PH_AK_LOW: begin
                        if (r_cmd == OP_CHECK) begin
                            nxt_ph = PH_SP_LOW;
                        end else begin
                            if (r_cmd == OP_ACK) n_sda = 1'b1;
                            finish = 1'b1;
                        end
                    end
                    PH_SP_LOW: nxt_ph = PH_SP_SCL;
                    PH_SP_SCL: nxt_ph = PH_SP_SDA;
                    PH_SP_SDA: begin
                        n_own  = 1'b0;
                        finish = 1'b1;
                    end
                    default: finish = 1'b1;
                endcase
                if (finish) begin
                    begin_en = 1'b0;
                    n_active = 1'b0;
                    n_done   = 1'b1;
                    n_phase  = PH_ST_REL;
                    n_dly    = '0;
                end
            end
        end else if (r_cmd_valid) begin
            n_cmd   = r_op;
            n_bit   = '0;
            n_shift = (r_op == OP_SEND || r_op == OP_CHECK) ? r_tx : '0;
            if (r_op == OP_CHECK && !(r_sda_in && r_scl_in)) begin
                // bus not idle: fault, no transaction
                n_ack  = 1'b1;
                n_done = 1'b1;
            end else begin
                n_active = 1'b1;
                begin_en = 1'b1;
                case (r_op)
                    OP_START: nxt_ph = PH_ST_REL;
                    OP_STOP:  nxt_ph = PH_SP_LOW;
                    OP_SEND:  nxt_ph = PH_TX_DATA;
                    OP_READ:  nxt_ph = PH_RX_HIGH;
                    OP_CHECK: nxt_ph = PH_ST_REL;
                    default:  nxt_ph = PH_AK_DATA;
                endcase
            end
        end

        if (begin_en) begin
            n_phase = nxt_ph;
            n_dly   = hold;
            case (nxt_ph)
                PH_ST_REL: begin
                    n_sda = 1'b1;
                    n_scl = 1'b1;
                    n_own = 1'b1;
                end
                PH_ST_SDA:  n_sda = 1'b0;
                PH_ST_SCL:  n_scl = 1'b0;
                PH_TX_DATA: n_sda = n_shift[BYTE_W-1];
                PH_TX_HIGH: n_scl = 1'b1;
                PH_TX_LOW: begin
                    n_scl = 1'b0;
                    if (n_bit == LAST_BIT) n_sda = 1'b1;   // release for ack
                    n_shift = {n_shift[BYTE_W-2:0], 1'b0};
                end
                PH_RX_HIGH: n_scl = 1'b1;
                PH_RX_LOW:  n_scl = 1'b0;
                PH_AK_DATA: n_sda = (n_cmd == OP_ACK) ? 1'b0 : 1'b1;
                PH_AK_HIGH: n_scl = 1'b1;
                PH_AK_LOW:  n_scl = 1'b0;
                PH_SP_LOW: begin
                    n_scl = 1'b0;
                    n_sda = 1'b0;
                end
                PH_SP_SCL:  n_scl = 1'b1;
                PH_SP_SDA:  n_sda = 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv     <= 1'b0;
            r_ov     <= 1'b0;
            r_half   <= HALF_RESET;
            r_cmd    <= OP_START;
            r_phase  <= PH_ST_REL;
            r_dly    <= '0;
            r_bit    <= '0;
            r_shift  <= '0;
            r_rd     <= '0;
            r_ack    <= 1'b1;
            r_own    <= 1'b0;
            r_scl    <= 1'b1;
            r_sda    <= 1'b1;
            r_active <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_half <= i_cfg_half_period_ticks;
            end
            if (o_in_ready) begin
                r_iv <= i_in_valid;
            end
            if (adv) begin
                r_ov     <= 1'b1;
                r_cmd    <= n_cmd;
                r_phase  <= n_phase;
                r_dly    <= n_dly;
                r_bit    <= n_bit;
                r_shift  <= n_shift;
                r_rd     <= n_rd;
                r_ack    <= n_ack;
                r_own    <= n_own;
                r_scl    <= n_scl;
                r_sda    <= n_sda;
                r_active <= n_active;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_cmd_valid <= i_cmd_valid;
            r_op        <= i_op;
            r_tx        <= i_tx_byte;
            r_sda_in    <= i_sda_in;
            r_scl_in    <= i_scl_in;
        end
        if (adv) begin
            r_o_scl  <= n_scl;
            r_o_sda  <= n_sda;
            r_o_busy <= n_active;
            r_o_done <= n_done;
            r_o_rx   <= n_rd;
            r_o_ack  <= n_ack;
            r_o_own  <= n_own;
        end
    end

    assign o_out_valid = r_ov;
    assign o_scl_drive = r_o_scl;
    assign o_sda_drive = r_o_sda;
    assign o_busy_res  = r_o_busy;
    assign o_done_res  = r_o_done;
    assign o_rx_byte   = r_o_rx;
    assign o_ack_bit   = r_o_ack;
    assign o_bus_owned = r_o_own;

endmodule

// ===== src/i2cms_checker.sv =====
// ----------------------------------------------------------------------------
// i2cms_checker
// Port-level checks on the I2C master bit engine, bound to the top level.
// ----------------------------------------------------------------------------
module i2cms_checker (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_out_ready,
    input  logic                    o_out_valid,
    input  logic                    o_scl_drive,
    input  logic                    o_sda_drive,
    input  logic                    o_busy_res,
    input  logic                    o_done_res,
    input  i2cms_pkg::t_byte        o_rx_byte,
    input  logic                    o_ack_bit,
    input  logic                    o_bus_owned
);
    import i2cms_pkg::*;

    logic   out_acc;
    t_byte  r_last_rx;
    logic   r_last_own;

    assign out_acc = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_rx  <= '0;
            r_last_own <= 1'b0;
        end else if (out_acc) begin
            r_last_rx  <= o_rx_byte;
            r_last_own <= o_bus_owned;
        end
    end

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_done_res) |-> !o_busy_res)
        else $error("done with busy set");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_scl_drive) && $stable(o_sda_drive)
             && $stable(o_rx_byte) && $stable(o_ack_bit) && $stable(o_bus_owned)))
        else $error("stalled result changed");

    a_rx_only_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && !o_done_res) |-> (o_rx_byte == r_last_rx))
        else $error("rx byte changed without completion");

    a_own_needs_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_bus_owned && !r_last_own) |-> o_busy_res)
        else $error("bus taken outside a command");

endmodule

bind i2c_master_bit_sequencer_top i2cms_checker u_i2cms_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_ready (i_out_ready),
    .o_out_valid (o_out_valid),
    .o_scl_drive (o_scl_drive),
    .o_sda_drive (o_sda_drive),
    .o_busy_res  (o_busy_res),
    .o_done_res  (o_done_res),
    .o_rx_byte   (o_rx_byte),
    .o_ack_bit   (o_ack_bit),
    .o_bus_owned (o_bus_owned)
);
